// ===== rtl/ttsb_pkg.sv =====
package ttsb_pkg;

  // Field widths of the channel payloads
  localparam int FLD_CHAR_W = 7;
  localparam int FLD_ROW_W  = 5;
  localparam int FLD_COL_W  = 6;

  localparam int ROWS_DEF = 24;
  localparam int COLS_DEF = 40;

  localparam logic [FLD_CHAR_W-1:0] CODE_BACK  = 7'h5F;
  localparam logic [FLD_CHAR_W-1:0] CODE_CR    = 7'h0D;
  localparam logic [FLD_CHAR_W-1:0] CODE_SPACE = 7'h20;
  localparam logic [FLD_CHAR_W-1:0] CODE_DEL   = 7'h7F;
  localparam logic [FLD_CHAR_W-1:0] CODE_MARK  = 7'h5F;

  typedef enum logic [1:0] {
    K_OTHER,
    K_BACK,
    K_CR,
    K_PRINT
  } code_kind_t;

  // Command from the sequencer to the cursor unit
  typedef struct packed {
    logic                  step;
    logic [FLD_CHAR_W-1:0] code;
  } cur_cmd_t;

  function automatic code_kind_t code_kind(input logic [FLD_CHAR_W-1:0] code);
    code_kind_t k;
    k = K_OTHER;
    if (code == CODE_BACK) begin
      k = K_BACK;
    end else if (code == CODE_CR) begin
      k = K_CR;
    end else if (code >= CODE_SPACE && code < CODE_DEL) begin
      k = K_PRINT;
    end
    return k;
  endfunction

endpackage

// ===== rtl/ttsb_if.sv =====
interface ttsb_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [ttsb_pkg::FLD_CHAR_W-1:0] char_in;
  logic [ttsb_pkg::FLD_ROW_W-1:0]  read_row;
  logic [ttsb_pkg::FLD_COL_W-1:0]  read_col;

  modport source (output valid, mode, char_in, read_row, read_col, input ready);
  modport sink (input valid, mode, char_in, read_row, read_col, output ready);
endinterface

interface ttsb_out_if;
  logic                            valid;
  logic                            ready;
  logic [ttsb_pkg::FLD_CHAR_W-1:0] cell_char;
  logic [ttsb_pkg::FLD_ROW_W-1:0]  cursor_row;
  logic [ttsb_pkg::FLD_COL_W-1:0]  cursor_col;

  modport source (output valid, cell_char, cursor_row, cursor_col, input ready);
  modport sink (input valid, cell_char, cursor_row, cursor_col, output ready);
endinterface

// ===== rtl/ttsb_ram.sv =====
module ttsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ttsb_cursor.sv =====
module ttsb_cursor #(
  parameter int SCREEN_ROWS = ttsb_pkg::ROWS_DEF,
  parameter int SCREEN_COLS = ttsb_pkg::COLS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  ttsb_pkg::cur_cmd_t                          cmd,
  output logic [$clog2(SCREEN_ROWS)-1:0]              row,
  output logic [$clog2(SCREEN_COLS)-1:0]              col,
  output logic [$clog2(SCREEN_ROWS*SCREEN_COLS)-1:0]  addr,
  output logic                                        scroll
);
  import ttsb_pkg::*;

  localparam int RW = $clog2(SCREEN_ROWS);
  localparam int CW = $clog2(SCREEN_COLS);
  localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);
  localparam logic [AW-1:0] COLS_A   = AW'(SCREEN_COLS);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  code_kind_t    kind;
  logic          new_line;

  assign kind = code_kind(cmd.code);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    new_line = 1'b0;
    unique case (kind)
      K_BACK: begin
        if (col_r != '0) begin
          col_nxt = col_r - 1'b1;
        end else if (row_r != '0) begin
          row_nxt = row_r - 1'b1;
          col_nxt = LAST_COL;
        end
      end
      K_CR: begin
        col_nxt  = '0;
        new_line = 1'b1;
      end
      K_PRINT: begin
        if (col_r == LAST_COL) begin
          col_nxt  = '0;
          new_line = 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      default: ;
    endcase
    // on the bottom row the cursor stays put and the store scrolls instead
    if (new_line && row_r != LAST_ROW) begin
      row_nxt = row_r + 1'b1;
    end
  end

  assign scroll = new_line && (row_r == LAST_ROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign row  = row_r;
  assign col  = col_r;
  assign addr = AW'(AW'(row_r) * COLS_A + AW'(col_r));

endmodule

// ===== rtl/text_terminal_screen_buffer_top.sv =====
// Text terminal screen store with a cursor, one RAM of SCREEN_ROWS x SCREEN_COLS seven-bit cells.
// Every input item gives one result with the cursor after it; a read item also returns the cell.
// All store traffic goes through the single write and single read port of the cell RAM under a
// small sequencer, and the block takes one item at a time. A read item passes through the read
// and done states, a character item that does not scroll through the mark and done states,
// before the result is loaded and ready returns. A character item that moves past the bottom
// row copies the store up one row and blanks the bottom row, one cell a cycle. After reset the
// block clears the store to spaces, one cell a cycle, and is not ready until that pass is done.
// A finished result waits in an output register; a new item is taken while it waits.
module text_terminal_screen_buffer_top #(
  parameter int SCREEN_ROWS = ttsb_pkg::ROWS_DEF,
  parameter int SCREEN_COLS = ttsb_pkg::COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ttsb_in_if.sink    in_chan,
  ttsb_out_if.source out_chan
);
  import ttsb_pkg::*;

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int KEEP  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int AW    = $clog2(CELLS);
  localparam int QW    = $clog2(CELLS + 1);
  localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLS);
  localparam logic [QW-1:0] COLS_Q = QW'(SCREEN_COLS);
  localparam logic [QW-1:0] KEEP_Q = QW'(KEEP);
  localparam logic [QW-1:0] LAST_Q = QW'(CELLS - 1);
  localparam logic [QW-1:0] END_Q  = QW'(CELLS);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_MARK   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [QW-1:0]         cnt_r, cnt_nxt;
  logic                  rng_r, rng_nxt;
  logic [FLD_CHAR_W-1:0] cell_r, cell_nxt;

  logic                  out_valid_r;
  logic [FLD_CHAR_W-1:0] out_cell_r;
  logic [FLD_ROW_W-1:0]  out_row_r;
  logic [FLD_COL_W-1:0]  out_col_r;
  logic                  load_out;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [FLD_CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [FLD_CHAR_W-1:0] ram_rdata;

  cur_cmd_t              cmd;
  logic [RW-1:0]         cur_row;
  logic [CW-1:0]         cur_col;
  logic [AW-1:0]         cur_addr;
  logic                  scroll;

  logic                  in_fire;
  logic                  out_free;
  logic                  rd_ok;
  logic [AW-1:0]         rd_addr;
  code_kind_t            kind;

  ttsb_ram #(
    .WIDTH (FLD_CHAR_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ttsb_cursor #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .row    (cur_row),
    .col    (cur_col),
    .addr   (cur_addr),
    .scroll (scroll)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign kind          = code_kind(in_chan.char_in);

  assign rd_ok   = (int'(in_chan.read_row) < SCREEN_ROWS) &&
                   (int'(in_chan.read_col) < SCREEN_COLS);
  assign rd_addr = AW'(AW'(in_chan.read_row) * COLS_A + AW'(in_chan.read_col));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rng_nxt   = rng_r;
    cell_nxt  = cell_r;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = CODE_SPACE;
    ram_raddr = '0;
    cmd.step  = 1'b0;
    cmd.code  = in_chan.char_in;
    load_out  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_r);
        if (cnt_r == LAST_Q) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.mode) begin
            rng_nxt   = rd_ok;
            ram_raddr = rd_ok ? rd_addr : '0;
            state_nxt = S_READ;
          end else begin
            // write the cell under the old cursor, then move it
            cmd.step  = 1'b1;
            cell_nxt  = '0;
            ram_we    = (kind != K_OTHER);
            ram_wdata = (kind == K_PRINT) ? in_chan.char_in : CODE_SPACE;
            cnt_nxt   = '0;
            state_nxt = scroll ? S_SCROLL : S_MARK;
          end
        end
      end
      S_READ: begin
        cell_nxt  = rng_r ? ram_rdata : '0;
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        // read one row below, write it back in the following cycle; blank the bottom row
        ram_raddr = (cnt_r < KEEP_Q) ? AW'(cnt_r + COLS_Q) : '0;
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cnt_r - 1'b1);
          ram_wdata = (cnt_r <= KEEP_Q) ? ram_rdata : CODE_SPACE;
        end
        if (cnt_r == END_Q) begin
          cnt_nxt   = '0;
          state_nxt = S_MARK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = CODE_MARK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rng_r  <= rng_nxt;
    cell_r <= cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cell_r <= cell_r;
      out_row_r  <= FLD_ROW_W'(cur_row);
      out_col_r  <= FLD_COL_W'(cur_col);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_char  = out_cell_r;
  assign out_chan.cursor_row = out_row_r;
  assign out_chan.cursor_col = out_col_r;

endmodule

// ===== rtl/ttsb_checker.sv =====
module ttsb_checker #(
  parameter int SCREEN_ROWS = ttsb_pkg::ROWS_DEF,
  parameter int SCREEN_COLS = ttsb_pkg::COLS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ttsb_pkg::FLD_ROW_W-1:0]  out_cursor_row,
  input logic [ttsb_pkg::FLD_COL_W-1:0]  out_cursor_col
);
  import ttsb_pkg::*;

  // the clearing pass keeps the input side closed straight after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is at work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_row) < SCREEN_ROWS) &&
                  (int'(out_cursor_col) < SCREEN_COLS))
    else $error("cursor outside the screen");

endmodule

bind text_terminal_screen_buffer_top ttsb_checker #(
  .SCREEN_ROWS (SCREEN_ROWS),
  .SCREEN_COLS (SCREEN_COLS)
) u_ttsb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_cursor_row (out_chan.cursor_row),
  .out_cursor_col (out_chan.cursor_col)
);

// ===== sim/tb_text_terminal_screen_buffer_top.sv =====
`timescale 1ns / 1ps

module tb_text_terminal_screen_buffer_top;
  import ttsb_pkg::*;

  localparam int ROWS        = ROWS_DEF;
  localparam int COLS        = COLS_DEF;
  localparam int RAND_ITEMS  = 380;
  localparam int CALM_TAIL   = 50;
  localparam int STALL_LIMIT = 4000;
  localparam int SHOW_MAX    = 10;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct {
    logic                  mode;
    logic [FLD_CHAR_W-1:0] char_in;
    logic [FLD_ROW_W-1:0]  read_row;
    logic [FLD_COL_W-1:0]  read_col;
  } term_item_t;

  typedef struct {
    logic [FLD_CHAR_W-1:0] cell_char;
    logic [FLD_ROW_W-1:0]  row;
    logic [FLD_COL_W-1:0]  col;
  } term_result_t;

  logic clk;
  logic rst_n;

  ttsb_in_if  in_if ();
  ttsb_out_if out_if ();

  text_terminal_screen_buffer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow copy of the screen and cursor
  logic [FLD_CHAR_W-1:0] screen_shadow [0:ROWS-1][0:COLS-1];
  int cur_row;
  int cur_col;

  term_item_t   char_q [$];
  term_result_t screen_q [$];
  int items_total;
  int items_taken;
  int errors;
  int stall_cycles;
  int in_hold;
  int out_hold;
  logic in_fire;

  function automatic term_result_t term_predict(input term_item_t it);
    term_result_t res;
    int row;
    int col;
    int r;
    int c;
    res.cell_char = '0;
    if (it.mode == MODE_READ) begin
      if (it.read_row < ROWS && it.read_col < COLS) begin
        res.cell_char = screen_shadow[it.read_row][it.read_col];
      end
    end else begin
      row = cur_row;
      col = cur_col;
      if (it.char_in == CODE_BACK) begin
        screen_shadow[row][col] = CODE_SPACE;
        if (col > 0) begin
          col--;
        end else if (row > 0) begin
          row--;
          col = COLS - 1;
        end
      end else if (it.char_in == CODE_CR) begin
        screen_shadow[row][col] = CODE_SPACE;
        col = 0;
        row++;
      end else if (it.char_in >= CODE_SPACE && it.char_in < CODE_DEL) begin
        screen_shadow[row][col] = it.char_in;
        col++;
        if (col >= COLS) begin
          col = 0;
          row++;
        end
      end
      // scroll up one row and blank the bottom
      if (row >= ROWS) begin
        row = ROWS - 1;
        for (r = 0; r < ROWS - 1; r++) begin
          for (c = 0; c < COLS; c++) begin
            screen_shadow[r][c] = screen_shadow[r+1][c];
          end
        end
        for (c = 0; c < COLS; c++) begin
          screen_shadow[ROWS-1][c] = CODE_SPACE;
        end
      end
      screen_shadow[row][col] = CODE_MARK;
      cur_row = row;
      cur_col = col;
    end
    res.row = FLD_ROW_W'(cur_row);
    res.col = FLD_COL_W'(cur_col);
    return res;
  endfunction

  task automatic add_char(input logic [FLD_CHAR_W-1:0] code);
    term_item_t it;
    it.mode     = MODE_CHAR;
    it.char_in  = code;
    it.read_row = FLD_ROW_W'($urandom);
    it.read_col = FLD_COL_W'($urandom);
    char_q.push_back(it);
  endtask

  task automatic add_read(input int row, input int col);
    term_item_t it;
    it.mode     = MODE_READ;
    it.char_in  = FLD_CHAR_W'($urandom);
    it.read_row = FLD_ROW_W'(row);
    it.read_col = FLD_COL_W'(col);
    char_q.push_back(it);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    errors++;
    if (errors <= SHOW_MAX) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, field, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Feed items from the queue, with random gaps until the tail of the run
  always @(negedge clk) begin
    term_item_t nxt;
    logic drive_v;
    drive_v = in_if.valid;
    if (rst_n && (!in_if.valid || in_fire)) begin
      drive_v = 1'b0;
      if (in_hold > 0) begin
        in_hold--;
      end else if (char_q.size() > 0) begin
        if (char_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          in_hold = $urandom_range(1, 14) - 1;
        end else begin
          nxt = char_q.pop_front();
          drive_v = 1'b1;
          in_if.mode     <= nxt.mode;
          in_if.char_in  <= nxt.char_in;
          in_if.read_row <= nxt.read_row;
          in_if.read_col <= nxt.read_col;
        end
      end
    end
    in_if.valid <= drive_v;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_if.ready <= 1'b0;
    end else if (char_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(1, 14) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    term_item_t   got_item;
    term_result_t want;
    logic out_fire;
    logic take;
    take     = rst_n && in_if.valid && in_if.ready;
    out_fire = rst_n && out_if.valid && out_if.ready;
    in_fire <= take;
    if (out_fire) begin
      if (screen_q.size() == 0) begin
        report_field("unexpected result", 0, out_if.cell_char);
      end else begin
        want = screen_q.pop_front();
        if (out_if.cell_char !== want.cell_char) begin
          report_field("cell_char", want.cell_char, out_if.cell_char);
        end
        if (out_if.cursor_row !== want.row) report_field("cursor_row", want.row, out_if.cursor_row);
        if (out_if.cursor_col !== want.col) report_field("cursor_col", want.col, out_if.cursor_col);
      end
    end
    if (take) begin
      got_item.mode     = in_if.mode;
      got_item.char_in  = in_if.char_in;
      got_item.read_row = in_if.read_row;
      got_item.read_col = in_if.read_col;
      screen_q.push_back(term_predict(got_item));
      items_taken++;
    end
    if (take || out_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_text_terminal_screen_buffer_top: errors");
    $finish;
  end

  initial begin
    int n;
    int pick;
    int r;
    int c;
    rst_n = 1'b0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_CHAR;
    in_if.char_in  = '0;
    in_if.read_row = '0;
    in_if.read_col = '0;
    out_if.ready   = 1'b0;
    in_fire        = 1'b0;
    in_hold        = 0;
    out_hold       = 0;
    items_taken    = 0;
    errors         = 0;
    stall_cycles   = 0;
    cur_row        = 0;
    cur_col        = 0;
    for (r = 0; r < ROWS; r++) begin
      for (c = 0; c < COLS; c++) begin
        screen_shadow[r][c] = CODE_SPACE;
      end
    end

    // directed part
    add_read(0, 0);
    add_char(CODE_BACK);              // backspace at home stays put
    add_read(0, 0);
    add_char(CODE_SPACE);
    add_char(7'h7E);
    add_char(7'h41);
    add_char(7'h00);                  // ignored codes still leave the mark
    add_char(CODE_DEL);
    add_char(7'h1F);
    add_char(CODE_CR);
    add_char(CODE_BACK);              // wraps to the end of the row above
    add_read(0, COLS - 1);
    add_char(7'h5A);
    add_read(0, COLS - 1);
    add_read(1, 0);
    add_read(ROWS - 1, COLS - 1);
    add_read(ROWS, 0);                // off-screen reads return zero
    add_read(0, COLS);
    add_read(31, 63);
    add_read(0, 1);

    for (n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if ($urandom_range(0, 6) == 0) begin
          add_read($urandom_range(0, 31), $urandom_range(0, 63));
        end else if ($urandom_range(0, 1) == 0) begin
          add_read($urandom_range(ROWS - 4, ROWS - 1), $urandom_range(0, COLS - 1));
        end else begin
          add_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        end
      end else if (pick < 40) begin
        add_char(CODE_CR);
      end else if (pick < 50) begin
        add_char(CODE_BACK);
      end else if (pick < 55) begin
        if ($urandom_range(0, 4) == 0) begin
          add_char(CODE_DEL);
        end else begin
          add_char(FLD_CHAR_W'($urandom_range(0, 31)));
        end
      end else begin
        add_char(FLD_CHAR_W'($urandom_range(CODE_SPACE, CODE_DEL - 1)));
      end
    end
    items_total = char_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (items_taken == items_total);
    wait (screen_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_text_terminal_screen_buffer_top: clean");
    end else begin
      $display("tb_text_terminal_screen_buffer_top: errors");
    end
    $finish;
  end

endmodule
